// ----- sv/bso_pkg.sv -----
// Shared types and constants for the box/sphere overlap tester.
`default_nettype none
package bso_pkg;

  // Width of each packed vector field on the request stream.
  localparam int FIELD_W    = 48;
  // Request tdata: first_position, first_extent, second_position, second_extent.
  localparam int IN_DATA_W  = 4 * FIELD_W;
  // Request tuser: pair kind.
  localparam int CMD_W      = 2;
  // Result tdata: overlapping bit padded to a byte.
  localparam int OUT_DATA_W = 8;

  typedef enum logic [CMD_W-1:0] {
    CMD_BOX_BOX       = 2'd0,
    CMD_BOX_SPHERE    = 2'd1,
    CMD_SPHERE_BOX    = 2'd2,
    CMD_SPHERE_SPHERE = 2'd3
  } cmd_e;

  // Box-box status handed to the final compare.
  typedef struct packed {
    logic box_pair;  // both shapes are boxes
    logic box_ovl;   // intervals overlap on all three axes
  } pair_flags_t;

endpackage
`default_nettype wire

// ----- sv/box_sphere_overlap_test.sv -----
// Top level of the box/sphere overlap tester: stream ports and pipeline.
`default_nettype none
// Box / sphere overlap tester. Each request carries a pair of 3D shapes and
// its kind on tuser (box-box, box-sphere, sphere-box, sphere-sphere); each
// request yields exactly one result byte whose bit 0 is set when the shapes
// strictly overlap (touching surfaces do not count). Coordinates, sizes and
// radii are signed fixed point, COORD_WIDTH bits per lane (Q11.4 at 16),
// packed x, y, z from the low bits of each 48-bit field; lane bits past
// bit 47 read as zero, and a sphere's radius is the lowest lane. Math is
// exact: no rounding, no saturation. The pipeline has three register
// stages (request register, per-axis squares, result register) and takes
// one request every cycle while results are taken; a request moves from the
// request register to the square register and then the result register. The
// multiply in the square stage sets the clock. Back pressure on the result
// side ripples back; the block keeps accepting while any stage has room.
module box_sphere_overlap_test #(
  parameter int COORD_WIDTH = 16
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  // request stream
  input  wire logic                             s_axis_tvalid,
  output logic                                  s_axis_tready,
  // [47:0] first_position, [95:48] first_extent,
  // [143:96] second_position, [191:144] second_extent
  input  wire logic [bso_pkg::IN_DATA_W-1:0]    s_axis_tdata,
  // [1:0] command
  input  wire logic [bso_pkg::CMD_W-1:0]        s_axis_tuser,
  // result stream
  output logic                                  m_axis_tvalid,
  input  wire logic                             m_axis_tready,
  // [0] overlapping, [7:1] zero
  output logic [bso_pkg::OUT_DATA_W-1:0]        m_axis_tdata
);

  localparam int CW     = COORD_WIDTH;
  localparam int FW     = bso_pkg::FIELD_W;
  localparam int PACK_W = (3 * CW > FW) ? 3 * CW : FW;
  localparam int SQ_W   = 2 * CW + 2;
  localparam int RW     = CW + 1;

  // ---------------- handshake: each stage moves when the next has room
  logic rdy0, rdy1, rdy2;
  logic in_acc, out_acc;
  logic s0_vld_q, s0_vld_d;
  logic s1_vld_q, s1_vld_d;
  logic out_vld_q, out_vld_d;

  assign rdy2 = !out_vld_q || m_axis_tready;
  assign rdy1 = !s1_vld_q || rdy2;
  assign rdy0 = !s0_vld_q || rdy1;

  assign s_axis_tready = rdy0;
  assign in_acc        = s_axis_tvalid && rdy0;
  assign out_acc       = out_vld_q && m_axis_tready;

  always_comb begin
    s0_vld_d  = rdy0 ? s_axis_tvalid : s0_vld_q;
    s1_vld_d  = rdy1 ? s0_vld_q : s1_vld_q;
    out_vld_d = rdy2 ? s1_vld_q : out_vld_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_vld_q  <= 1'b0;
      s1_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      s0_vld_q  <= s0_vld_d;
      s1_vld_q  <= s1_vld_d;
      out_vld_q <= out_vld_d;
    end
  end

  // ---------------- stage 0: request register
  bso_pkg::cmd_e   cmd_q;
  logic [FW-1:0]   p1_q, e1_q, p2_q, e2_q;

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      cmd_q <= bso_pkg::cmd_e'(s_axis_tuser);
      p1_q  <= s_axis_tdata[0*FW +: FW];
      e1_q  <= s_axis_tdata[1*FW +: FW];
      p2_q  <= s_axis_tdata[2*FW +: FW];
      e2_q  <= s_axis_tdata[3*FW +: FW];
    end
  end

  // Zero-extend so lanes reaching past bit 47 read zero there.
  logic [PACK_W-1:0] p1_ext, e1_ext, p2_ext, e2_ext;
  assign p1_ext = PACK_W'(p1_q);
  assign e1_ext = PACK_W'(e1_q);
  assign p2_ext = PACK_W'(p2_q);
  assign e2_ext = PACK_W'(e2_q);

  logic [SQ_W-1:0] sq [3];
  logic [2:0]      axis_ovl;

  for (genvar i = 0; i < 3; i++) begin : g_axis
    bso_axis #(
      .COORD_WIDTH(CW)
    ) u_axis (
      .cmd_i (cmd_q),
      .p1_i  (p1_ext[i*CW +: CW]),
      .s1_i  (e1_ext[i*CW +: CW]),
      .p2_i  (p2_ext[i*CW +: CW]),
      .s2_i  (e2_ext[i*CW +: CW]),
      .sq_o  (sq[i]),
      .ovl_o (axis_ovl[i])
    );
  end

  // Effective radius: the sphere's own, or the signed sum of both.
  logic signed [CW-1:0]     r1, r2;
  logic signed [RW-1:0]     rad;
  logic signed [SQ_W-1:0]   rad_x, rsq;

  assign r1 = e1_ext[CW-1:0];
  assign r2 = e2_ext[CW-1:0];

  always_comb begin
    case (cmd_q)
      bso_pkg::CMD_BOX_SPHERE:    rad = RW'(r2);
      bso_pkg::CMD_SPHERE_BOX:    rad = RW'(r1);
      bso_pkg::CMD_SPHERE_SPHERE: rad = RW'(r1) + RW'(r2);
      default:                    rad = '0;
    endcase
  end

  assign rad_x = SQ_W'(rad);
  assign rsq   = rad_x * rad_x;

  // ---------------- stage 1: squares and box flags
  logic [SQ_W-1:0]      sq_q [3];
  logic [SQ_W-1:0]      rsq_q;
  bso_pkg::pair_flags_t flags_q;

  always_ff @(posedge clk_i) begin
    if (s0_vld_q && rdy1) begin
      sq_q[0]          <= sq[0];
      sq_q[1]          <= sq[1];
      sq_q[2]          <= sq[2];
      rsq_q            <= rsq;
      flags_q.box_pair <= (cmd_q == bso_pkg::CMD_BOX_BOX);
      flags_q.box_ovl  <= &axis_ovl;
    end
  end

  logic hit;

  bso_judge #(
    .COORD_WIDTH(CW)
  ) u_judge (
    .sq_i    (sq_q),
    .rsq_i   (rsq_q),
    .flags_i (flags_q),
    .hit_o   (hit)
  );

  // ---------------- stage 2: result register
  logic hit_q;

  always_ff @(posedge clk_i) begin
    if (s1_vld_q && rdy2) begin
      hit_q <= hit;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {{(bso_pkg::OUT_DATA_W-1){1'b0}}, hit_q};

  // ---------------- checks
  // Back pressure reaches the request side only with every stage full.
  a_full_when_stalled: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> (s0_vld_q && s1_vld_q && out_vld_q))
    else $error("request side stalled with a free stage");

  // An accepted request lands in the request register.
  a_req_captured: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> s0_vld_q)
    else $error("accepted request not captured");

  // Without a request in or a result out, the item count holds.
  a_count_kept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!in_acc && !out_acc) |=>
      ($countones({s0_vld_q, s1_vld_q, out_vld_q}) ==
       $past($countones({s0_vld_q, s1_vld_q, out_vld_q}))))
    else $error("request lost or duplicated in pipeline");

endmodule
`default_nettype wire

// ----- sv/bso_axis.sv -----
// One axis of the pair test: interval overlap and squared clamp distance.
`default_nettype none
module bso_axis #(
  parameter int COORD_WIDTH = 16
) (
  input  var bso_pkg::cmd_e            cmd_i,
  input  wire logic signed [COORD_WIDTH-1:0] p1_i,
  input  wire logic signed [COORD_WIDTH-1:0] s1_i,
  input  wire logic signed [COORD_WIDTH-1:0] p2_i,
  input  wire logic signed [COORD_WIDTH-1:0] s2_i,
  output logic [2*COORD_WIDTH+1:0]     sq_o,
  output logic                         ovl_o
);

  localparam int EW   = COORD_WIDTH + 1;    // bound / clamp width
  localparam int DW   = COORD_WIDTH + 2;    // difference width
  localparam int PW   = 2 * COORD_WIDTH + 4; // full signed square
  localparam int SQ_W = 2 * COORD_WIDTH + 2; // square magnitude

  logic signed [EW-1:0] a_lo, a_hi, b_lo, b_hi;
  logic signed [EW-1:0] lo, hi, ctr, low_clip, clamped;
  logic signed [DW-1:0] diff;
  logic signed [PW-1:0] diff_x, prod;

  assign a_lo = EW'(p1_i);
  assign a_hi = EW'(p1_i) + EW'(s1_i);
  assign b_lo = EW'(p2_i);
  assign b_hi = EW'(p2_i) + EW'(s2_i);

  // Strict overlap, touching faces do not count.
  assign ovl_o = (a_lo < b_hi) && (a_hi > b_lo);

  // Sphere-sphere reuses the clamp with a degenerate box at the second centre.
  always_comb begin
    case (cmd_i)
      bso_pkg::CMD_BOX_SPHERE: begin
        lo  = a_lo;
        hi  = a_hi;
        ctr = b_lo;
      end
      bso_pkg::CMD_SPHERE_BOX: begin
        lo  = b_lo;
        hi  = b_hi;
        ctr = a_lo;
      end
      default: begin
        lo  = b_lo;
        hi  = b_lo;
        ctr = a_lo;
      end
    endcase
  end

  // max then min: an inverted box clamps to hi.
  assign low_clip = (ctr < lo) ? lo : ctr;
  assign clamped  = (low_clip > hi) ? hi : low_clip;

  assign diff   = DW'(ctr) - DW'(clamped);
  assign diff_x = PW'(diff);
  assign prod   = diff_x * diff_x;
  assign sq_o   = prod[SQ_W-1:0];

endmodule
`default_nettype wire

// ----- sv/bso_judge.sv -----
// Final decision: sum of squared distances against squared radius, or the box-box overlap flag.
`default_nettype none
module bso_judge #(
  parameter int COORD_WIDTH = 16
) (
  input  wire logic [2*COORD_WIDTH+1:0] sq_i [3],
  input  wire logic [2*COORD_WIDTH+1:0] rsq_i,
  input  var bso_pkg::pair_flags_t      flags_i,
  output logic                          hit_o
);

  localparam int SQ_W  = 2 * COORD_WIDTH + 2;
  localparam int ACC_W = SQ_W + 2;

  logic [ACC_W-1:0] acc;

  assign acc   = ACC_W'(sq_i[0]) + ACC_W'(sq_i[1]) + ACC_W'(sq_i[2]);
  assign hit_o = flags_i.box_pair ? flags_i.box_ovl : (acc < ACC_W'(rsq_i));

endmodule
`default_nettype wire

// ----- tb/testbench.sv -----
// Self-checking testbench for the box/sphere overlap tester.
`default_nettype none
module testbench;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int COORD_W     = 16;
  localparam int CYCLE_LIMIT = 100000;  // well above the slowest correct run
  localparam int RANDOM_REQS = 480;
  localparam int NO_EXP      = -1;      // directed row checked by the predictor

  typedef struct {
    bso_pkg::cmd_e cmd;
    logic [47:0]   p1, e1, p2, e2;
    int            typed_hit;            // 0/1 typed in, or NO_EXP
  } stim_row_t;

  typedef struct {
    bit hit;
    int req_idx;
  } overlap_rec_t;

  logic                           clk_i = 1'b0;
  logic                           rst_ni = 1'b0;
  logic                           s_axis_tvalid = 1'b0;
  logic                           s_axis_tready;
  // [47:0] first_position, [95:48] first_extent,
  // [143:96] second_position, [191:144] second_extent
  logic [bso_pkg::IN_DATA_W-1:0]  s_axis_tdata = '0;
  // [1:0] command
  logic [bso_pkg::CMD_W-1:0]      s_axis_tuser = '0;
  logic                           m_axis_tvalid;
  logic                           m_axis_tready = 1'b0;
  // [0] overlapping, [7:1] zero
  logic [bso_pkg::OUT_DATA_W-1:0] m_axis_tdata;

  stim_row_t    dir_rows[$];
  overlap_rec_t pending_overlap[$];
  int           mismatches = 0;
  int           results_seen = 0;
  int           cycles = 0;
  bit           no_gaps = 1'b0;         // both sides run without idling

  box_sphere_overlap_test #(.COORD_WIDTH(COORD_W)) u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Overlap predictor. Lanes are signed COORD_W-bit fixed point, x from bit 0;
  // lane bits past bit 47 read as zero. All math is exact in 64 bits.
  // ---------------------------------------------------------------------------
  function automatic longint lane_of(logic [47:0] packed_v, int idx);
    logic [63:0] u;
    u = ({16'b0, packed_v} >> (idx * COORD_W)) & ((64'd1 << COORD_W) - 1);
    if (u[COORD_W-1])
      return longint'(u) - (longint'(1) << COORD_W);
    return longint'(u);
  endfunction

  // Clamp the centre into the box, compare squared distance with r squared.
  function automatic bit box_sphere_hit(logic [47:0] bp, logic [47:0] bs,
                                        logic [47:0] sp, logic [47:0] se);
    longint acc, rad, lo, hi, c, v;
    acc = 0;
    rad = lane_of(se, 0);
    for (int i = 0; i < 3; i++) begin
      lo = lane_of(bp, i);
      hi = lo + lane_of(bs, i);
      c  = lane_of(sp, i);
      v  = c;
      if (v < lo) v = lo;
      if (v > hi) v = hi;   // reversed box ends up at hi
      acc += (c - v) * (c - v);
    end
    return acc < rad * rad;
  endfunction

  function automatic bit shapes_overlap(bso_pkg::cmd_e cmd,
                                        logic [47:0] p1, logic [47:0] e1,
                                        logic [47:0] p2, logic [47:0] e2);
    longint amin, amax, bmin, bmax, acc, rad, d;
    bit     hit;
    case (cmd)
      bso_pkg::CMD_BOX_BOX: begin
        hit = 1'b1;
        for (int i = 0; i < 3; i++) begin
          amin = lane_of(p1, i);
          amax = amin + lane_of(e1, i);
          bmin = lane_of(p2, i);
          bmax = bmin + lane_of(e2, i);
          if (!(amin < bmax && amax > bmin)) hit = 1'b0;
        end
      end
      bso_pkg::CMD_BOX_SPHERE: hit = box_sphere_hit(p1, e1, p2, e2);
      bso_pkg::CMD_SPHERE_BOX: hit = box_sphere_hit(p2, e2, p1, e1);
      default: begin
        acc = 0;
        rad = lane_of(e1, 0) + lane_of(e2, 0);   // signed sum of the radii
        for (int i = 0; i < 3; i++) begin
          d = lane_of(p1, i) - lane_of(p2, i);
          acc += d * d;
        end
        hit = acc < rad * rad;
      end
    endcase
    return hit;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  function automatic logic [47:0] vec(logic [15:0] x, logic [15:0] y, logic [15:0] z);
    return {z, y, x};
  endfunction

  function automatic void add_row(bso_pkg::cmd_e cmd, logic [47:0] p1, logic [47:0] e1,
                                  logic [47:0] p2, logic [47:0] e2, int typed_hit);
    stim_row_t r;
    r.cmd = cmd;
    r.p1 = p1;
    r.e1 = e1;
    r.p2 = p2;
    r.e2 = e2;
    r.typed_hit = typed_hit;
    dir_rows.push_back(r);
  endfunction

  function automatic logic [15:0] near(logic [15:0] base, int spread);
    return base + 16'($urandom_range(0, 2 * spread)) - 16'(spread);
  endfunction

  // Mostly positive, now and then negated.
  function automatic logic [15:0] rand_size(int spread);
    logic [15:0] s;
    s = 16'($urandom_range(0, spread));
    if ($urandom_range(0, 7) == 0) s = -s;
    return s;
  endfunction

  function automatic logic [47:0] rand48();
    return {16'($urandom), 32'($urandom)};
  endfunction

  // A quarter of the pairs are raw noise; the rest sit close together so that
  // hits, misses and near-touching cases all come up often.
  task automatic make_random_pair(output bso_pkg::cmd_e cmd, output logic [47:0] p1,
                                  output logic [47:0] e1, output logic [47:0] p2,
                                  output logic [47:0] e2);
    int          spread;
    logic [15:0] base[3];
    cmd = bso_pkg::cmd_e'($urandom_range(0, 3));
    if ($urandom_range(0, 3) == 0) begin
      p1 = rand48();
      e1 = rand48();
      p2 = rand48();
      e2 = rand48();
    end else begin
      case ($urandom_range(0, 2))
        0:       spread = 16;
        1:       spread = 256;
        default: spread = 4096;
      endcase
      for (int i = 0; i < 3; i++) base[i] = 16'($urandom);
      p1 = vec(near(base[0], spread), near(base[1], spread), near(base[2], spread));
      p2 = vec(near(base[0], spread), near(base[1], spread), near(base[2], spread));
      // Box sizes fill all lanes; a radius sits in lane 0 over junk upper lanes.
      e1 = (cmd == bso_pkg::CMD_BOX_BOX || cmd == bso_pkg::CMD_BOX_SPHERE)
         ? vec(rand_size(spread), rand_size(spread), rand_size(spread))
         : {32'($urandom), rand_size(spread)};
      e2 = (cmd == bso_pkg::CMD_BOX_BOX || cmd == bso_pkg::CMD_SPHERE_BOX)
         ? vec(rand_size(spread), rand_size(spread), rand_size(spread))
         : {32'($urandom), rand_size(spread)};
    end
  endtask

  task automatic report_mismatch(input string msg);
    mismatches++;
    $display("MISMATCH: %s", msg);
  endtask

  // ---------------------------------------------------------------------------
  // Request side
  // ---------------------------------------------------------------------------
  initial begin
    stim_row_t    row;
    overlap_rec_t rec;
    int           total;

    // Directed rows; 16'h0010 is 1.0 in Q11.4.
    add_row(bso_pkg::CMD_BOX_BOX,       '0, '0, '0, '0, 0);  // degenerate boxes
    add_row(bso_pkg::CMD_BOX_BOX,       '1, '1, '1, '1, 0);  // reversed, empty
    add_row(bso_pkg::CMD_SPHERE_SPHERE, '0, '0, '0, '0, 0);  // zero radii
    add_row(bso_pkg::CMD_SPHERE_SPHERE, '1, '1, '1, '1, 1);  // radius sum -2
    add_row(bso_pkg::CMD_BOX_SPHERE,    '1, '1, '1, '1, 0);
    add_row(bso_pkg::CMD_SPHERE_BOX,    '1, '1, '1, '1, 0);
    add_row(bso_pkg::CMD_SPHERE_SPHERE, vec(16'h7fff, 16'h7fff, 16'h7fff), 48'h7fff,
            vec(16'h8000, 16'h8000, 16'h8000), 48'h7fff, 0); // farthest apart
    add_row(bso_pkg::CMD_SPHERE_SPHERE, vec(16'h7fff, 16'h7fff, 16'h7fff), 48'h7fff,
            vec(16'h7fff, 16'h7fff, 16'h7fff), 48'h7fff, 1);
    // faces touch on x
    add_row(bso_pkg::CMD_BOX_BOX, '0, vec(16'h10, 16'h10, 16'h10),
            vec(16'h10, 16'h0, 16'h0), vec(16'h10, 16'h10, 16'h10), 0);
    add_row(bso_pkg::CMD_BOX_BOX, '0, vec(16'h10, 16'h10, 16'h10),
            vec(16'h8, 16'h8, 16'h8), vec(16'h10, 16'h10, 16'h10), 1);
    // spheres touch, then just overlap
    add_row(bso_pkg::CMD_SPHERE_SPHERE, '0, 48'h10,
            vec(16'h20, 16'h0, 16'h0), 48'h10, 0);
    add_row(bso_pkg::CMD_SPHERE_SPHERE, '0, 48'h10,
            vec(16'h1f, 16'h0, 16'h0), 48'h10, 1);
    // centre inside the box
    add_row(bso_pkg::CMD_BOX_SPHERE, '0, vec(16'h20, 16'h20, 16'h20),
            vec(16'h10, 16'h10, 16'h10), 48'h1, 1);
    // sphere touches a box face, in both orders
    add_row(bso_pkg::CMD_BOX_SPHERE, '0, vec(16'h10, 16'h10, 16'h10),
            vec(16'h18, 16'h8, 16'h8), 48'h8, 0);
    add_row(bso_pkg::CMD_SPHERE_BOX, vec(16'h18, 16'h8, 16'h8), 48'h8,
            '0, vec(16'h10, 16'h10, 16'h10), 0);
    add_row(bso_pkg::CMD_SPHERE_BOX, vec(16'h17, 16'h8, 16'h8), 48'h8,
            '0, vec(16'h10, 16'h10, 16'h10), 1);
    // zero radius never overlaps, even from inside
    add_row(bso_pkg::CMD_BOX_SPHERE, '0, vec(16'h20, 16'h20, 16'h20),
            vec(16'h10, 16'h10, 16'h10), 48'h0, 0);
    // negative radius
    add_row(bso_pkg::CMD_BOX_SPHERE, '0, vec(16'h10, 16'h10, 16'h10),
            vec(16'h17, 16'h8, 16'h8), 48'hfff8, NO_EXP);
    add_row(bso_pkg::CMD_SPHERE_SPHERE, '0, 48'h10,
            vec(16'h4, 16'h0, 16'h0), 48'hfff0, NO_EXP);
    // negative box sizes
    add_row(bso_pkg::CMD_BOX_BOX, vec(16'h10, 16'h10, 16'h10),
            vec(16'hfff0, 16'hfff0, 16'hfff0),
            vec(16'h8, 16'h8, 16'h8), vec(16'h4, 16'h4, 16'h4), NO_EXP);
    add_row(bso_pkg::CMD_BOX_SPHERE, vec(16'h10, 16'h10, 16'h10),
            vec(16'hfff0, 16'hfff0, 16'hfff0),
            vec(16'h8, 16'h8, 16'h8), 48'h20, NO_EXP);
    // junk in the unused radius lanes
    add_row(bso_pkg::CMD_SPHERE_SPHERE, '0, 48'ha5a5_5a5a_0010,
            vec(16'h18, 16'h0, 16'h0), 48'hffff_ffff_0010, NO_EXP);
    add_row(bso_pkg::CMD_BOX_BOX, vec(16'h8000, 16'h8000, 16'h8000),
            vec(16'h7fff, 16'h7fff, 16'h7fff), vec(16'h7fff, 16'h7fff, 16'h7fff),
            vec(16'h7fff, 16'h7fff, 16'h7fff), NO_EXP);
    add_row(bso_pkg::CMD_SPHERE_SPHERE, vec(16'h7fff, 16'h7fff, 16'h7fff), 48'h8000,
            vec(16'h8000, 16'h8000, 16'h8000), 48'h8000, NO_EXP);

    total = dir_rows.size() + RANDOM_REQS;

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    for (int n = 0; n < total; n++) begin
      if (n < dir_rows.size()) begin
        row = dir_rows[n];
      end else begin
        make_random_pair(row.cmd, row.p1, row.e1, row.p2, row.e2);
        row.typed_hit = NO_EXP;
      end
      // Calm stretch in the middle of the random part.
      no_gaps = (n >= 250 && n < 350);

      while (!no_gaps && $urandom_range(0, 99) < 17) begin
        s_axis_tvalid <= 1'b0;
        @(posedge clk_i);
      end
      s_axis_tvalid <= 1'b1;
      s_axis_tdata  <= {row.e2, row.p2, row.e1, row.p1};
      s_axis_tuser  <= row.cmd;
      @(posedge clk_i);
      while (!s_axis_tready) @(posedge clk_i);

      // Request accepted at this edge.
      rec.req_idx = n;
      rec.hit = (row.typed_hit == NO_EXP)
              ? shapes_overlap(row.cmd, row.p1, row.e1, row.p2, row.e2)
              : row.typed_hit[0];
      pending_overlap.push_back(rec);
    end
    s_axis_tvalid <= 1'b0;
    no_gaps = 1'b0;

    while (pending_overlap.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);   // catch any stray result past the pipeline

    if (mismatches == 0) begin
      $display("box_sphere_overlap_test test passed");
    end else begin
      $display("box_sphere_overlap_test test failed");
    end
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Result side: random back pressure and the in-order check
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin : result_check
    overlap_rec_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      results_seen++;
      if (pending_overlap.size() == 0) begin
        report_mismatch($sformatf("result %0d with no request waiting, tdata=%02h",
                                  results_seen, m_axis_tdata));
      end else begin
        want = pending_overlap.pop_front();
        if (m_axis_tdata !== {7'b0, want.hit})
          report_mismatch($sformatf("request %0d: overlapping got tdata=%02h, want %0d",
                                    want.req_idx, m_axis_tdata, want.hit));
      end
    end
    m_axis_tready <= no_gaps || ($urandom_range(0, 99) >= 17);
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("box_sphere_overlap_test test failed");
      $finish;
    end
  end

endmodule
`default_nettype wire

// ----- box_sphere_overlap_test.f -----
sv/bso_pkg.sv
sv/bso_axis.sv
sv/bso_judge.sv
sv/box_sphere_overlap_test.sv
tb/testbench.sv
